FILE: hw/rtl/gzhp_pkg.sv
package gzhp_pkg;

  // Parser phase codes
  localparam int PhaseW = 5;
  localparam logic [PhaseW-1:0] PH_MAGIC1  = 5'd0;
  localparam logic [PhaseW-1:0] PH_MAGIC2  = 5'd1;
  localparam logic [PhaseW-1:0] PH_METHOD  = 5'd2;
  localparam logic [PhaseW-1:0] PH_FLAGS   = 5'd3;
  localparam logic [PhaseW-1:0] PH_TIME0   = 5'd4;
  localparam logic [PhaseW-1:0] PH_TIME1   = 5'd5;
  localparam logic [PhaseW-1:0] PH_TIME2   = 5'd6;
  localparam logic [PhaseW-1:0] PH_TIME3   = 5'd7;
  localparam logic [PhaseW-1:0] PH_XFL     = 5'd8;
  localparam logic [PhaseW-1:0] PH_OS      = 5'd9;
  localparam logic [PhaseW-1:0] PH_XLEN_LO = 5'd10;
  localparam logic [PhaseW-1:0] PH_XLEN_HI = 5'd11;
  localparam logic [PhaseW-1:0] PH_XSKIP   = 5'd12;
  localparam logic [PhaseW-1:0] PH_NAME    = 5'd13;
  localparam logic [PhaseW-1:0] PH_COMMENT = 5'd14;
  localparam logic [PhaseW-1:0] PH_BODY    = 5'd15;
  localparam logic [PhaseW-1:0] PH_ERROR   = 5'd16;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_METHOD   = 3'd2;
  localparam logic [2:0] ERR_CRYPT    = 3'd3;
  localparam logic [2:0] ERR_MULTI    = 3'd4;
  localparam logic [2:0] ERR_RESERVED = 3'd5;

  // Header bytes and flag bits
  localparam logic [7:0] MAGIC_ID1     = 8'h1f;
  localparam logic [7:0] MAGIC_ID2     = 8'h8b;
  localparam logic [7:0] MAGIC_ID2_OLD = 8'h9e;
  localparam logic [7:0] METHOD_DEFL   = 8'h08;
  localparam logic [7:0] FLG_MULTI     = 8'h02;
  localparam logic [7:0] FLG_EXTRA     = 8'h04;
  localparam logic [7:0] FLG_NAME      = 8'h08;
  localparam logic [7:0] FLG_COMMENT   = 8'h10;
  localparam logic [7:0] FLG_CRYPT     = 8'h20;
  localparam logic [7:0] FLG_RESERVED  = 8'hc0;

  typedef struct packed {
    logic       restart;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        header_done;
    logic        body_byte;
    logic        error_flag;
    logic [2:0]  error_code;
    logic [31:0] mtime;
    logic [7:0]  flag_bits;
  } out_item_t;

  // Next optional section at or after 'from'; PH_BODY ends the header
  function automatic logic [PhaseW-1:0] next_section(input logic [PhaseW-1:0] from,
                                                     input logic [7:0] flags);
    logic [PhaseW-1:0] res;
    if (from <= PH_XLEN_LO && (flags & FLG_EXTRA) != 8'd0) begin
      res = PH_XLEN_LO;
    end else if (from <= PH_NAME && (flags & FLG_NAME) != 8'd0) begin
      res = PH_NAME;
    end else if (from <= PH_COMMENT && (flags & FLG_COMMENT) != 8'd0) begin
      res = PH_COMMENT;
    end else begin
      res = PH_BODY;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/gzip_header_parser.sv
// An accepted byte passes through the input register and then the result register to become its result item.
// Throughput: one byte per cycle while no result is held by dst_stall; the single parser state update sets the pace.
// The input register takes one more byte while a result is held by dst_stall.
// Reset (rst, synchronous, active high): both stages empty, parser waits for the
// first magic byte, stamp, flags and error code cleared.
module gzip_header_parser
  import gzhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      dst_valid,
  input  logic      dst_stall,
  output out_item_t dst_item
);

  logic      hold_valid;
  in_item_t  hold_item;
  logic      advance;
  out_item_t step_result;

  // Result register frees up when empty or when its item is taken
  assign advance   = !dst_valid || !dst_stall;
  assign src_stall = hold_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!src_stall) begin
      hold_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!src_stall && src_valid) begin
      hold_item <= src_item;
    end
  end

  gzhp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (hold_valid && advance),
    .item   (hold_item),
    .result (step_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (advance) begin
      dst_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_valid) begin
      dst_item <= step_result;
    end
  end

  // Checks
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (dst_item.error_flag == (dst_item.error_code != ERR_NONE)))
    else $error("error flag disagrees with error code");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_item.error_flag) |-> (!dst_item.header_done && !dst_item.body_byte))
    else $error("header end or body marked on a rejected header");

  a_done_body: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> !(dst_item.header_done && dst_item.body_byte))
    else $error("header end and body marked on one byte");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_stall) |=> (dst_valid && $stable(dst_item)))
    else $error("stalled result item changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!dst_valid && !src_stall))
    else $error("pipeline not empty after reset");

endmodule

FILE: hw/rtl/gzhp_core.sv
module gzhp_core
  import gzhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t result
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [7:0]        first_magic, first_magic_next;
  logic [7:0]        flag_store, flag_store_next;
  logic [15:0]       skip_count, skip_count_next;
  logic [31:0]       stamp_acc, stamp_acc_next;
  logic [2:0]        error_latch, error_latch_next;

  // restart clears state before the byte is parsed
  logic [PhaseW-1:0] ph;
  logic [7:0]        fm, fl;
  logic [15:0]       sk;
  logic [31:0]       st;
  logic [2:0]        er;
  logic [7:0]        b;
  logic              body;

  assign ph = item.restart ? PH_MAGIC1 : phase;
  assign fm = item.restart ? 8'd0 : first_magic;
  assign fl = item.restart ? 8'd0 : flag_store;
  assign sk = item.restart ? 16'd0 : skip_count;
  assign st = item.restart ? 32'd0 : stamp_acc;
  assign er = item.restart ? ERR_NONE : error_latch;
  assign b  = item.data_byte;

  // Per-byte phase step
  always_comb begin
    phase_next       = ph;
    first_magic_next = fm;
    flag_store_next  = fl;
    skip_count_next  = sk;
    stamp_acc_next   = st;
    error_latch_next = er;
    body             = 1'b0;
    case (ph)
      PH_MAGIC1: begin
        first_magic_next = b;
        phase_next       = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        if (fm == MAGIC_ID1 && (b == MAGIC_ID2 || b == MAGIC_ID2_OLD)) begin
          phase_next = PH_METHOD;
        end else begin
          error_latch_next = ERR_MAGIC;
          phase_next       = PH_ERROR;
        end
      end
      PH_METHOD: begin
        if (b == METHOD_DEFL) begin
          phase_next = PH_FLAGS;
        end else begin
          error_latch_next = ERR_METHOD;
          phase_next       = PH_ERROR;
        end
      end
      PH_FLAGS: begin
        flag_store_next = b;
        if ((b & FLG_CRYPT) != 8'd0) begin
          error_latch_next = ERR_CRYPT;
          phase_next       = PH_ERROR;
        end else if ((b & FLG_MULTI) != 8'd0) begin
          error_latch_next = ERR_MULTI;
          phase_next       = PH_ERROR;
        end else if ((b & FLG_RESERVED) != 8'd0) begin
          error_latch_next = ERR_RESERVED;
          phase_next       = PH_ERROR;
        end else begin
          phase_next = PH_TIME0;
        end
      end
      PH_TIME0: begin
        stamp_acc_next = st | {24'd0, b};
        phase_next     = PH_TIME1;
      end
      PH_TIME1: begin
        stamp_acc_next = st | {16'd0, b, 8'd0};
        phase_next     = PH_TIME2;
      end
      PH_TIME2: begin
        stamp_acc_next = st | {8'd0, b, 16'd0};
        phase_next     = PH_TIME3;
      end
      PH_TIME3: begin
        stamp_acc_next = st | {b, 24'd0};
        phase_next     = PH_XFL;
      end
      PH_XFL: begin
        phase_next = PH_OS;
      end
      PH_OS: begin
        phase_next = next_section(PH_XLEN_LO, fl);
      end
      PH_XLEN_LO: begin
        skip_count_next = {8'd0, b};
        phase_next      = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        skip_count_next = {b, sk[7:0]};
        phase_next = ({b, sk[7:0]} != 16'd0) ? PH_XSKIP : next_section(PH_NAME, fl);
      end
      PH_XSKIP: begin
        skip_count_next = sk - 16'd1;
        if (sk == 16'd1) begin
          phase_next = next_section(PH_NAME, fl);
        end
      end
      PH_NAME: begin
        if (b == 8'd0) begin
          phase_next = next_section(PH_COMMENT, fl);
        end
      end
      PH_COMMENT: begin
        if (b == 8'd0) begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      default: begin
        phase_next = PH_ERROR;
      end
    endcase
  end

  // Result fields for this byte
  always_comb begin
    result.header_done = (phase_next == PH_BODY) && !body;
    result.body_byte   = body;
    result.error_flag  = (error_latch_next != ERR_NONE);
    result.error_code  = error_latch_next;
    result.mtime       = stamp_acc_next;
    result.flag_bits   = flag_store_next;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_MAGIC1;
      first_magic <= 8'd0;
      flag_store  <= 8'd0;
      skip_count  <= 16'd0;
      stamp_acc   <= 32'd0;
      error_latch <= ERR_NONE;
    end else if (step) begin
      phase       <= phase_next;
      first_magic <= first_magic_next;
      flag_store  <= flag_store_next;
      skip_count  <= skip_count_next;
      stamp_acc   <= stamp_acc_next;
      error_latch <= error_latch_next;
    end
  end

endmodule

FILE: tb/gzip_header_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the gzip header parser, tracks the header state
// from every accepted byte and checks each returned status item in order.
module gzip_header_checker
  import gzhp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_stall,
  input  in_item_t  src_item,
  input  logic      dst_valid,
  input  logic      dst_stall,
  input  out_item_t dst_item,
  output int        mismatches,
  output int        outstanding
);

  // Tracked header state
  logic [PhaseW-1:0] phase;
  logic [7:0]        id1_seen;
  logic [7:0]        flags_seen;
  logic [15:0]       xlen_left;
  logic [31:0]       stamp;
  logic [2:0]        err_code;

  // Status items still owed by the parser, oldest first
  out_item_t byte_status_q[$];

  // First optional section at or past 'from' that the flags ask for
  function automatic logic [PhaseW-1:0] section_after(input logic [PhaseW-1:0] from);
    logic [PhaseW-1:0] nxt;
    nxt = PH_BODY;
    if (from <= PH_COMMENT && (flags_seen & FLG_COMMENT) != 8'd0) nxt = PH_COMMENT;
    if (from <= PH_NAME && (flags_seen & FLG_NAME) != 8'd0) nxt = PH_NAME;
    if (from <= PH_XLEN_LO && (flags_seen & FLG_EXTRA) != 8'd0) nxt = PH_XLEN_LO;
    return nxt;
  endfunction

  task automatic clear_header();
    phase      = PH_MAGIC1;
    id1_seen   = 8'd0;
    flags_seen = 8'd0;
    xlen_left  = 16'd0;
    stamp      = 32'd0;
    err_code   = ERR_NONE;
  endtask

  task automatic reject(input logic [2:0] code);
    err_code = code;
    phase    = PH_ERROR;
  endtask

  // Advance the header state by one byte and form its status item
  task automatic parse_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic       in_body;
    b       = it.data_byte;
    in_body = 1'b0;
    if (it.restart) clear_header();
    case (phase)
      PH_MAGIC1: begin
        id1_seen = b;
        phase    = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        if (id1_seen == MAGIC_ID1 && (b == MAGIC_ID2 || b == MAGIC_ID2_OLD)) phase = PH_METHOD;
        else reject(ERR_MAGIC);
      end
      PH_METHOD: begin
        if (b == METHOD_DEFL) phase = PH_FLAGS;
        else reject(ERR_METHOD);
      end
      PH_FLAGS: begin
        flags_seen = b;
        // encrypted wins over multi-part, which wins over reserved
        if ((b & FLG_CRYPT) != 8'd0) reject(ERR_CRYPT);
        else if ((b & FLG_MULTI) != 8'd0) reject(ERR_MULTI);
        else if ((b & FLG_RESERVED) != 8'd0) reject(ERR_RESERVED);
        else phase = PH_TIME0;
      end
      PH_TIME0: begin
        stamp = stamp | {24'd0, b};
        phase = PH_TIME1;
      end
      PH_TIME1: begin
        stamp = stamp | {16'd0, b, 8'd0};
        phase = PH_TIME2;
      end
      PH_TIME2: begin
        stamp = stamp | {8'd0, b, 16'd0};
        phase = PH_TIME3;
      end
      PH_TIME3: begin
        stamp = stamp | {b, 24'd0};
        phase = PH_XFL;
      end
      PH_XFL: phase = PH_OS;
      PH_OS: phase = section_after(PH_XLEN_LO);
      PH_XLEN_LO: begin
        xlen_left = {8'd0, b};
        phase     = PH_XLEN_HI;
      end
      PH_XLEN_HI: begin
        xlen_left = {b, xlen_left[7:0]};
        // zero length: nothing to skip, header may end right here
        phase = (xlen_left != 16'd0) ? PH_XSKIP : section_after(PH_NAME);
      end
      PH_XSKIP: begin
        xlen_left = xlen_left - 16'd1;
        if (xlen_left == 16'd0) phase = section_after(PH_NAME);
      end
      PH_NAME: begin
        if (b == 8'd0) phase = section_after(PH_COMMENT);
      end
      PH_COMMENT: begin
        if (b == 8'd0) phase = PH_BODY;
      end
      PH_BODY: in_body = 1'b1;
      default: phase = PH_ERROR;
    endcase
    res.header_done = (phase == PH_BODY) && !in_body;
    res.body_byte   = in_body;
    res.error_flag  = (err_code != ERR_NONE);
    res.error_code  = err_code;
    res.mtime       = stamp;
    res.flag_bits   = flags_seen;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // Predict on the input side, compare on the output side
  always @(posedge clk) begin
    out_item_t fresh;
    out_item_t want;
    if (rst) begin
      clear_header();
      byte_status_q.delete();
    end else begin
      if (src_valid && !src_stall) begin
        parse_byte(src_item, fresh);
        byte_status_q.push_back(fresh);
      end
      if (dst_valid && !dst_stall) begin
        if (byte_status_q.size() == 0) begin
          report_mismatch("unrequested item (mtime)", 32'd0, dst_item.mtime);
        end else begin
          want = byte_status_q.pop_front();
          if (dst_item.header_done !== want.header_done)
            report_mismatch("header_done", 32'(want.header_done),
                            32'(dst_item.header_done));
          if (dst_item.body_byte !== want.body_byte)
            report_mismatch("body_byte", 32'(want.body_byte), 32'(dst_item.body_byte));
          if (dst_item.error_flag !== want.error_flag)
            report_mismatch("error_flag", 32'(want.error_flag),
                            32'(dst_item.error_flag));
          if (dst_item.error_code !== want.error_code)
            report_mismatch("error_code", 32'(want.error_code),
                            32'(dst_item.error_code));
          if (dst_item.mtime !== want.mtime)
            report_mismatch("mtime", want.mtime, dst_item.mtime);
          if (dst_item.flag_bits !== want.flag_bits)
            report_mismatch("flag_bits", 32'(want.flag_bits), 32'(dst_item.flag_bits));
        end
      end
    end
    outstanding = byte_status_q.size();
  end

endmodule

FILE: tb/gzip_header_parser_tb.sv
`timescale 1ns / 100ps

module gzip_header_parser_tb;
  import gzhp_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int RandomBytes = 1860;
  localparam int DrainCycles = 20;

  typedef logic [7:0] byte_q_t[$];

  logic      clk = 1'b0;
  logic      rst;
  logic      src_valid;
  logic      src_stall;
  in_item_t  src_item;
  logic      dst_valid;
  logic      dst_stall;
  out_item_t dst_item;

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int src_gap_pct = 0;
  int dst_gap_pct = 0;

  // Whole byte stream, built before reset is released
  in_item_t stream_q[$];

  gzip_header_parser dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_item (dst_item)
  );

  gzip_header_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .dst_valid  (dst_valid),
    .dst_stall  (dst_stall),
    .dst_item   (dst_item),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    dst_stall <= ($urandom_range(99) < dst_gap_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Append one member; restart goes on its first byte only
  task automatic queue_member(input logic first_restart, input byte_q_t bytes);
    for (int i = 0; i < bytes.size(); i++) begin
      stream_q.push_back(in_item_t'{restart: (i == 0) && first_restart,
                                    data_byte: bytes[i]});
    end
  endtask

  // Well-formed header with random content, sometimes damaged or cut short
  task automatic queue_random_member();
    byte_q_t    hdr;
    logic [7:0] flg;
    int         xlen;
    int         pick;
    int         cut;
    pick = $urandom_range(99);
    flg  = 8'($urandom_range(1));
    if ($urandom_range(1)) flg = flg | FLG_EXTRA;
    if ($urandom_range(1)) flg = flg | FLG_NAME;
    if ($urandom_range(1)) flg = flg | FLG_COMMENT;
    hdr.push_back(MAGIC_ID1);
    hdr.push_back($urandom_range(1) ? MAGIC_ID2 : MAGIC_ID2_OLD);
    hdr.push_back(METHOD_DEFL);
    hdr.push_back(flg);
    // time stamp, extra flags, OS
    repeat (6) hdr.push_back(8'($urandom_range(255)));
    if ((flg & FLG_EXTRA) != 8'd0) begin
      // mostly short extra fields, now and then one past 255
      xlen = ($urandom_range(24) == 0) ? $urandom_range(300, 256) : $urandom_range(5);
      hdr.push_back(xlen[7:0]);
      hdr.push_back(xlen[15:8]);
      repeat (xlen) hdr.push_back(8'($urandom_range(255)));
    end
    if ((flg & FLG_NAME) != 8'd0) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'd0);
    end
    if ((flg & FLG_COMMENT) != 8'd0) begin
      repeat ($urandom_range(5)) hdr.push_back(8'($urandom_range(255, 1)));
      hdr.push_back(8'd0);
    end
    repeat ($urandom_range(6)) hdr.push_back(8'($urandom_range(255)));
    // broken members: a corrupted byte, a truncation, or a bad flag byte
    if (pick < 12) begin
      cut      = $urandom_range(hdr.size() - 1);
      hdr[cut] = 8'($urandom_range(255));
    end else if (pick < 20) begin
      cut = $urandom_range(hdr.size() - 1);
      hdr = hdr[0:cut];
    end else if (pick < 25) begin
      hdr[3] = 8'($urandom_range(255));
      if ((hdr[3] & (FLG_MULTI | FLG_CRYPT | FLG_RESERVED)) == 8'd0)
        hdr[3] = hdr[3] | FLG_MULTI;
    end
    queue_member($urandom_range(29) != 0, hdr);
  endtask

  // Hold the item until accepted; sender gaps go in front of it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < src_gap_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  initial begin
    int directed;
    rst       = 1'b1;
    src_valid = 1'b0;
    src_item  = '0;
    dst_stall = 1'b0;

    // No restart after reset; empty extra field ends the header on the
    // high length byte, then one body byte. Stamp bytes at both extremes.
    queue_member(1'b0, '{MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, FLG_EXTRA,
                         8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 8'h00,
                         8'h00, 8'h00, 8'hff});
    // Restart in the body; encrypted and multi-part together, then a byte
    // swallowed by the error state
    queue_member(1'b1, '{MAGIC_ID1, MAGIC_ID2_OLD, METHOD_DEFL,
                         FLG_CRYPT | FLG_MULTI | 8'h01, 8'h55});
    queue_member(1'b1, '{MAGIC_ID1, 8'h00});
    queue_member(1'b1, '{MAGIC_ID1, MAGIC_ID2, 8'h07});
    queue_member(1'b1, '{MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, FLG_RESERVED | FLG_MULTI});
    queue_member(1'b1, '{MAGIC_ID1, MAGIC_ID2, METHOD_DEFL, 8'h80});
    directed = stream_q.size();
    while (stream_q.size() < directed + RandomBytes) queue_random_member();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Three idling regimes: slow receiver, slow sender, then full rate
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i < stream_q.size() / 3) begin
        src_gap_pct = 13;
        dst_gap_pct = 81;
      end else if (i < 2 * stream_q.size() / 3) begin
        src_gap_pct = 81;
        dst_gap_pct = 13;
      end else begin
        src_gap_pct = 0;
        dst_gap_pct = 0;
      end
      send_item(stream_q[i]);
    end
    src_valid <= 1'b0;

    // Drain, then let the pipeline settle
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
